@@ rtl/dssm_pkg.sv @@
package dssm_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = 7;
  localparam int ITEM_W     = 32;

  typedef logic [1:0]            cmd_t;
  typedef logic [2:0]            status_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic signed [ITEM_W-1:0] item_t;

  localparam cmd_t CMD_PUSH    = 2'd0;
  localparam cmd_t CMD_POP     = 2'd1;
  localparam cmd_t CMD_DISPLAY = 2'd2;
  localparam cmd_t CMD_INVALID = 2'd3;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_OVERFLOW  = 3'd1;
  localparam status_t ST_UNDERFLOW = 3'd2;
  localparam status_t ST_EMPTY     = 3'd3;
  localparam status_t ST_INVALID   = 3'd4;

  // An item is kept in the low DATA_WIDTH bits of an entry.
  function automatic word_t to_word(item_t item);
    return DATA_WIDTH'(unsigned'(item));
  endfunction

  // An entry reads back sign-extended from DATA_WIDTH bits, cut to the item width.
  function automatic item_t from_word(word_t w);
    return ITEM_W'(signed'(w));
  endfunction

  // A written capacity of zero means one entry; anything above DEPTH means DEPTH.
  function automatic cnt_t clamp_capacity(logic [CAP_W-1:0] v);
    logic [CAP_W-1:0] c;
    c = v;
    if (c == '0) begin
      c = CAP_W'(1);
    end else if (c > CAP_W'(DEPTH)) begin
      c = CAP_W'(DEPTH);
    end
    return CNT_W'(c);
  endfunction

endpackage

@@ rtl/dssm_if.sv @@
interface dssm_req_if;
  logic                 valid;
  logic                 ready;
  dssm_pkg::cmd_t       cmd;
  logic                 stack_select;
  dssm_pkg::item_t      push_value;

  modport source (output valid, cmd, stack_select, push_value, input ready);
  modport sink   (input valid, cmd, stack_select, push_value, output ready);
endinterface

interface dssm_rsp_if;
  logic                 valid;
  logic                 ready;
  dssm_pkg::status_t    status;
  dssm_pkg::item_t      value;
  logic                 last;

  modport source (output valid, status, value, last, input ready);
  modport sink   (input valid, status, value, last, output ready);
endinterface

interface dssm_cfg_if;
  logic                 valid;
  logic                 ready;
  logic [6:0]           capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

@@ rtl/dual_stack_shared_memory.sv @@
// Push, invalid: result in the cycle after the request; one request per cycle if unstalled.
// Pop: the result goes through the registered memory read, then the output register.
// Display of n elements: one element per cycle, unless stalled, from the single read port.
// A stalled result holds its output register and the next request waits for it.
// Reset empties both stacks and sets the capacity to DEPTH; memory contents are not cleared.
module dual_stack_shared_memory (
  input  logic            clk,
  input  logic            rst,
  dssm_req_if.sink        req,
  dssm_rsp_if.source      rsp,
  dssm_cfg_if.sink        cfg
);
  import dssm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_DISP = 2'd2;

  word_t store [DEPTH];
  word_t rdata;

  logic [1:0] state, state_next;
  cnt_t       count_a, count_a_next;
  cnt_t       count_b, count_b_next;
  cnt_t       capacity;
  cnt_t       disp_left, disp_left_next;
  addr_t      disp_ptr, disp_ptr_next;
  logic       disp_b, disp_b_next;

  logic       rsp_valid, rsp_valid_next;
  status_t    rsp_status, rsp_status_next;
  item_t      rsp_value, rsp_value_next;
  logic       rsp_last, rsp_last_next;

  logic       rd_en, wr_en;
  addr_t      rd_addr, wr_addr;
  word_t      wr_data;

  logic       out_free, req_fire, cfg_fire;
  logic [CNT_W:0] fill;

  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign cfg_fire  = cfg.valid;
  assign fill      = (CNT_W+1)'(count_a) + (CNT_W+1)'(count_b);

  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.value  = rsp_value;
  assign rsp.last   = rsp_last;

  always_comb begin
    state_next      = state;
    count_a_next    = count_a;
    count_b_next    = count_b;
    disp_left_next  = disp_left;
    disp_ptr_next   = disp_ptr;
    disp_b_next     = disp_b;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_status_next = rsp_status;
    rsp_value_next  = rsp_value;
    rsp_last_next   = rsp_last;
    rd_en           = 1'b0;
    rd_addr         = disp_ptr;
    wr_en           = 1'b0;
    wr_addr         = count_a[ADDR_W-1:0];
    wr_data         = to_word(req.push_value);

    case (state)
      S_IDLE: begin
        if (req_fire) begin
          rsp_value_next = '0;
          rsp_last_next  = 1'b1;
          rsp_status_next = ST_OK;
          case (req.cmd)
            CMD_PUSH: begin
              rsp_valid_next = 1'b1;
              if (fill >= (CNT_W+1)'(capacity)) begin
                rsp_status_next = ST_OVERFLOW;
              end else if (req.stack_select) begin
                wr_en        = 1'b1;
                wr_addr      = ADDR_W'(capacity - count_b - CNT_W'(1));
                count_b_next = count_b + CNT_W'(1);
              end else begin
                wr_en        = 1'b1;
                wr_addr      = count_a[ADDR_W-1:0];
                count_a_next = count_a + CNT_W'(1);
              end
            end
            CMD_POP: begin
              if (req.stack_select ? (count_b == '0) : (count_a == '0)) begin
                rsp_valid_next  = 1'b1;
                rsp_status_next = ST_UNDERFLOW;
              end else begin
                rd_en = 1'b1;
                if (req.stack_select) begin
                  rd_addr      = ADDR_W'(capacity - count_b);
                  count_b_next = count_b - CNT_W'(1);
                end else begin
                  rd_addr      = ADDR_W'(count_a - CNT_W'(1));
                  count_a_next = count_a - CNT_W'(1);
                end
                state_next = S_POP;
              end
            end
            CMD_DISPLAY: begin
              if (req.stack_select ? (count_b == '0) : (count_a == '0)) begin
                rsp_valid_next  = 1'b1;
                rsp_status_next = ST_EMPTY;
              end else begin
                // Read the first element now; the rest follow one per emitted result.
                rd_en       = 1'b1;
                disp_b_next = req.stack_select;
                if (req.stack_select) begin
                  rd_addr        = ADDR_W'(capacity - CNT_W'(1));
                  disp_ptr_next  = ADDR_W'(capacity - CNT_W'(2));
                  disp_left_next = count_b;
                end else begin
                  rd_addr        = '0;
                  disp_ptr_next  = ADDR_W'(1);
                  disp_left_next = count_a;
                end
                state_next = S_DISP;
              end
            end
            default: begin
              rsp_valid_next  = 1'b1;
              rsp_status_next = ST_INVALID;
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          rsp_valid_next  = 1'b1;
          rsp_status_next = ST_OK;
          rsp_value_next  = from_word(rdata);
          rsp_last_next   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_DISP: begin
        // The read data register holds the next element until it can be emitted.
        if (out_free) begin
          rsp_valid_next  = 1'b1;
          rsp_status_next = ST_OK;
          rsp_value_next  = from_word(rdata);
          rsp_last_next   = (disp_left == CNT_W'(1));
          disp_left_next  = disp_left - CNT_W'(1);
          if (disp_left == CNT_W'(1)) begin
            state_next = S_IDLE;
          end else begin
            rd_en         = 1'b1;
            rd_addr       = disp_ptr;
            disp_ptr_next = disp_b ? disp_ptr - ADDR_W'(1) : disp_ptr + ADDR_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Writing the capacity empties both stacks.
    if (cfg_fire) begin
      count_a_next = '0;
      count_b_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_a   <= '0;
      count_b   <= '0;
      capacity  <= CNT_W'(DEPTH);
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count_a   <= count_a_next;
      count_b   <= count_b_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_fire) begin
        capacity <= clamp_capacity(cfg.capacity);
      end
    end
  end

  always_ff @(posedge clk) begin
    disp_left  <= disp_left_next;
    disp_ptr   <= disp_ptr_next;
    disp_b     <= disp_b_next;
    rsp_status <= rsp_status_next;
    rsp_value  <= rsp_value_next;
    rsp_last   <= rsp_last_next;
  end

  a_fill_within_capacity: assert property (@(posedge clk) disable iff (rst)
    fill <= (CNT_W+1)'(capacity))
    else $error("stacks hold more entries than the capacity");

  a_display_has_elements: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISP) |-> (disp_left != '0))
    else $error("display running with no element left");

  a_pop_reads_memory: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.cmd == CMD_POP && state_next == S_POP) |=> (state == S_POP && !rsp_valid))
    else $error("pop did not wait for its memory read");

  a_display_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISP && out_free && disp_left == CNT_W'(1)) |=> (state == S_IDLE && rsp_last))
    else $error("display did not end on its last element");

endmodule

@@ tb/dssm_checker.sv @@
module dssm_checker
  import dssm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dssm_req_if  req,
  dssm_rsp_if  rsp,
  dssm_cfg_if  cfg,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t status;
    item_t   value;
    logic    last;
  } stack_result_t;

  stack_result_t pending_results[$];
  word_t         stack_mem[DEPTH];
  int            cnt_a;
  int            cnt_b;
  int            cap;

  task automatic report_mismatch(string what);
    // Keep the log short when a broken block floods us with mismatches.
    if (errors < 100) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    errors++;
  endtask

  function automatic item_t entry_value(int idx);
    word_t w;
    w = stack_mem[idx];
    return item_t'($signed(w));
  endfunction

  task automatic queue_result(status_t st, item_t val, logic is_last);
    stack_result_t r;
    r.status = st;
    r.value  = val;
    r.last   = is_last;
    pending_results.push_back(r);
  endtask

  task automatic set_capacity(logic [6:0] raw);
    if (raw == 7'd0) begin
      cap = 1;
    end else if (int'(raw) > DEPTH) begin
      cap = DEPTH;
    end else begin
      cap = int'(raw);
    end
    cnt_a = 0;
    cnt_b = 0;
  endtask

  task automatic predict_request(cmd_t op, logic sel_b, item_t item);
    int n;
    int idx;
    case (op)
      CMD_PUSH: begin
        if (cnt_a + cnt_b >= cap) begin
          queue_result(ST_OVERFLOW, '0, 1'b1);
        end else begin
          if (sel_b) begin
            cnt_b++;
            stack_mem[cap - cnt_b] = word_t'($unsigned(item));
          end else begin
            stack_mem[cnt_a] = word_t'($unsigned(item));
            cnt_a++;
          end
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      CMD_POP: begin
        n = sel_b ? cnt_b : cnt_a;
        if (n == 0) begin
          queue_result(ST_UNDERFLOW, '0, 1'b1);
        end else if (sel_b) begin
          queue_result(ST_OK, entry_value(cap - cnt_b), 1'b1);
          cnt_b--;
        end else begin
          cnt_a--;
          queue_result(ST_OK, entry_value(cnt_a), 1'b1);
        end
      end
      CMD_DISPLAY: begin
        n = sel_b ? cnt_b : cnt_a;
        if (n == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          // Stack B is listed from the top of the shared space downward.
          for (int i = 0; i < n; i++) begin
            idx = sel_b ? cap - 1 - i : i;
            queue_result(ST_OK, entry_value(idx), i == n - 1);
          end
        end
      end
      default: begin
        queue_result(ST_INVALID, '0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    stack_result_t want;
    if (rst) begin
      pending_results.delete();
      cnt_a  = 0;
      cnt_b  = 0;
      cap    = DEPTH;
      errors = 0;
    end else begin
      // Results are matched first: a result can never belong to a request
      // accepted at the same edge.
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d value=%0d last=%0b",
                                    rsp.status, rsp.value, rsp.last));
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
          end
          if (rsp.value !== want.value) begin
            report_mismatch($sformatf("value %0d, expected %0d", rsp.value, want.value));
          end
          if (rsp.last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", rsp.last, want.last));
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        set_capacity(cfg.capacity);
      end
      if (req.valid && req.ready) begin
        predict_request(req.cmd, req.stack_select, req.push_value);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

@@ tb/testbench.sv @@
module testbench;
  import dssm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst;
  logic quiet;
  int   check_errors;
  int   results_left;

  dssm_req_if req_ch ();
  dssm_rsp_if rsp_ch ();
  dssm_cfg_if cfg_ch ();

  dual_stack_shared_memory u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  dssm_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg         (cfg_ch),
    .errors      (check_errors),
    .outstanding (results_left)
  );

  always #4 clk = ~clk;

  // Mostly back to back, often a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 30);
  endfunction

  function automatic cmd_t pick_cmd(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      return CMD_PUSH;
    end else if (r < push_pct + (100 - push_pct) / 2) begin
      return CMD_POP;
    end else if (r < 94) begin
      return CMD_DISPLAY;
    end
    return CMD_INVALID;
  endfunction

  task automatic send_req(cmd_t op, logic sel_b, item_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= op;
    req_ch.stack_select <= sel_b;
    req_ch.push_value   <= item;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (results_left == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [6:0] raw);
    drain();
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= raw;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: bursts of ready broken by stalls of random length.
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = quiet ? 1 : $urandom_range(1, 8);
      rsp_ch.ready <= 1'b1;
      repeat (n) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    int phase_cap[7];
    int phase_len[7];
    int phase_push[7];
    quiet               = 1'b0;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.cmd          <= CMD_PUSH;
    req_ch.stack_select <= 1'b0;
    req_ch.push_value   <= '0;
    rsp_ch.ready        <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.capacity     <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty stacks, bad commands, extreme values, then both stacks listed and popped.
    send_req(CMD_DISPLAY, 1'b0, '0);
    send_req(CMD_DISPLAY, 1'b1, '0);
    send_req(CMD_POP, 1'b0, '0);
    send_req(CMD_POP, 1'b1, '0);
    send_req(CMD_INVALID, 1'b0, 32'h1234_5678);
    send_req(CMD_INVALID, 1'b1, '0);
    send_req(CMD_PUSH, 1'b0, 32'h7fff_ffff);
    send_req(CMD_PUSH, 1'b0, 32'h8000_0000);
    send_req(CMD_PUSH, 1'b1, 32'hffff_ffff);
    send_req(CMD_PUSH, 1'b1, '0);
    send_req(CMD_DISPLAY, 1'b0, '0);
    send_req(CMD_DISPLAY, 1'b1, '0);
    send_req(CMD_POP, 1'b1, '0);
    send_req(CMD_POP, 1'b0, '0);
    send_req(CMD_PUSH, 1'b1, 32'h5555_aaaa);

    // A capacity of zero is taken as one entry, so the stacks meet at once.
    write_capacity(7'd0);
    send_req(CMD_PUSH, 1'b1, 32'haaaa_5555);
    send_req(CMD_PUSH, 1'b0, 32'h0000_0001);
    send_req(CMD_PUSH, 1'b1, 32'h0000_0002);
    send_req(CMD_DISPLAY, 1'b1, '0);
    send_req(CMD_POP, 1'b1, '0);
    send_req(CMD_PUSH, 1'b0, 32'hdead_beef);
    send_req(CMD_POP, 1'b0, '0);

    // Anything above the memory size is clipped to it.
    write_capacity(7'h7f);
    send_req(CMD_DISPLAY, 1'b0, '0);

    phase_cap  = '{127, 4, 1, 64, 0, 2, 0};
    phase_len  = '{16, 14, 10, 20, 14, 12, 14};
    phase_push = '{55, 50, 40, 60, 50, 45, 50};
    phase_cap[4] = $urandom_range(1, 64);
    phase_cap[6] = $urandom_range(0, 127);
    for (int p = 0; p < 7; p++) begin
      write_capacity(7'(phase_cap[p]));
      quiet = (p == 1 || p == 5);
      for (int i = 0; i < phase_len[p]; i++) begin
        send_req(pick_cmd(phase_push[p]), 1'($urandom_range(0, 1)), item_t'($urandom));
      end
    end
    quiet = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    if (check_errors == 0 && results_left == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
